// File: rtl/core/tiet_pkg.sv
// Shared types and constants for the task and interrupt execution time profiler.
// No dependencies; used by tiet_ctrl, tiet_dp and the top level.
package tiet_pkg;

    localparam int TASK_COUNT = 64;
    localparam int INT_COUNT  = 32;
    localparam int TIME_BITS  = 32;

    localparam int TASK_IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int IRQ_IDX_W  = (INT_COUNT > 1) ? $clog2(INT_COUNT) : 1;

    localparam int CMD_W      = 3;
    localparam int TASK_W     = 6;
    localparam int INT_W      = 8;
    localparam int WORD_W     = 32;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_TASK  = 3'd0,
        CMD_READ_TASK = 3'd1,
        CMD_SET_IRQ   = 3'd2,
        CMD_READ_IRQ  = 3'd3,
        CMD_SWITCH    = 3'd4,
        CMD_ISR_START = 3'd5,
        CMD_ISR_END   = 3'd6
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INT = 1'd0,
        CFG_MAX_INT = 1'd1
    } cfg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the transaction and read both tables
        logic commit;   // write back, update state, load the result
    } dp_ctl_t;

endpackage

// File: rtl/core/tiet_ctrl.sv
// Controller for the profiler: input/output handshake and two-state sequencer.
// Depends on tiet_pkg.
module tiet_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output tiet_pkg::dp_ctl_t ctl
);
    import tiet_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   capture;
    logic   commit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign capture   = (state_reg == ST_IDLE) && in_valid;
    // a finished result may only leave once the output register is free
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    assign ctl.capture = capture;
    assign ctl.commit  = commit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/tiet_dp.sv
// Datapath for the profiler: counter memories with valid bits, time stamp,
// running task, range registers and result register. Depends on tiet_pkg.
module tiet_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tiet_pkg::dp_ctl_t               ctl,
    input  logic                            cfg_we,
    input  logic [tiet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tiet_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [tiet_pkg::CMD_W-1:0]      cmd,
    input  logic [tiet_pkg::WORD_W-1:0]     now_time,
    input  logic [tiet_pkg::TASK_W-1:0]     task_id,
    input  logic [tiet_pkg::TASK_W-1:0]     next_task,
    input  logic [tiet_pkg::INT_W-1:0]      int_num,
    input  logic [tiet_pkg::WORD_W-1:0]     set_value,
    output logic [tiet_pkg::WORD_W-1:0]     read_value,
    output logic                            status
);
    import tiet_pkg::*;

    // counter memories
    logic [TIME_BITS-1:0]  task_mem [TASK_COUNT];
    logic [TIME_BITS-1:0]  irq_mem  [INT_COUNT];
    logic [TASK_COUNT-1:0] task_vld_reg;
    logic [INT_COUNT-1:0]  irq_vld_reg;

    // persistent state
    logic [INT_W-1:0]     min_int_reg;
    logic [INT_W-1:0]     max_int_reg;
    logic [TIME_BITS-1:0] stamp_reg;
    logic [TASK_W-1:0]    running_reg;

    // per-transaction registers
    cmd_t                  cmd_reg;
    logic [TASK_IDX_W-1:0] task_addr_reg;
    logic                  task_ok_reg;
    logic [IRQ_IDX_W-1:0]  irq_addr_reg;
    logic                  irq_ok_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [TASK_W-1:0]     next_task_reg;
    logic [TIME_BITS-1:0]  set_value_reg;
    logic [TIME_BITS-1:0]  task_rd_reg;
    logic [TIME_BITS-1:0]  irq_rd_reg;

    // result
    logic [WORD_W-1:0] read_value_reg;
    logic [WORD_W-1:0] read_value_next;
    logic              status_reg;
    logic              status_next;

    // address decode at capture
    logic [TASK_W-1:0]     task_src;
    logic                  task_ok;
    logic [TASK_IDX_W-1:0] task_raddr;
    logic [INT_W-1:0]      irq_off;
    logic                  irq_ok;
    logic [IRQ_IDX_W-1:0]  irq_raddr;

    // write-back
    logic                 task_we;
    logic [TIME_BITS-1:0] task_wdata;
    logic                 irq_we;
    logic [TIME_BITS-1:0] irq_wdata;
    logic                 stamp_we;
    logic                 running_we;

    always_comb
    begin
        task_src   = (cmd_t'(cmd) == CMD_ISR_START) ? running_reg : task_id;
        task_ok    = (32'(task_src) < 32'(TASK_COUNT));
        task_raddr = TASK_IDX_W'(task_src);

        irq_off   = int_num - min_int_reg;
        irq_ok    = (int_num >= min_int_reg) && (int_num <= max_int_reg)
                    && (9'(irq_off) < 9'(INT_COUNT));
        irq_raddr = IRQ_IDX_W'(irq_off);
    end

    always_comb
    begin
        task_we         = 1'b0;
        task_wdata      = task_rd_reg + elapsed_reg;
        irq_we          = 1'b0;
        irq_wdata       = irq_rd_reg + elapsed_reg;
        stamp_we        = 1'b0;
        running_we      = 1'b0;
        read_value_next = '0;
        status_next     = 1'b0;
        case (cmd_reg)
            CMD_SET_TASK:
            begin
                task_we    = task_ok_reg;
                task_wdata = set_value_reg;
            end
            CMD_READ_TASK:
            begin
                read_value_next = task_ok_reg ? WORD_W'(task_rd_reg) : '0;
            end
            CMD_SET_IRQ:
            begin
                irq_we      = irq_ok_reg;
                irq_wdata   = set_value_reg;
                status_next = !irq_ok_reg;
            end
            CMD_READ_IRQ:
            begin
                read_value_next = irq_ok_reg ? WORD_W'(irq_rd_reg) : '0;
                status_next     = !irq_ok_reg;
            end
            CMD_SWITCH:
            begin
                task_we    = task_ok_reg;
                stamp_we   = 1'b1;
                running_we = 1'b1;
            end
            CMD_ISR_START:
            begin
                task_we  = task_ok_reg;
                stamp_we = 1'b1;
            end
            CMD_ISR_END:
            begin
                irq_we      = irq_ok_reg;
                stamp_we    = 1'b1;
                status_next = !irq_ok_reg;
            end
            default:
            begin
                read_value_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_int_reg  <= '0;
            max_int_reg  <= INT_W'(31);
            stamp_reg    <= '0;
            running_reg  <= '0;
            task_vld_reg <= '0;
            irq_vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MIN_INT: min_int_reg <= cfg_data;
                    CFG_MAX_INT: max_int_reg <= cfg_data;
                    default:     min_int_reg <= min_int_reg;
                endcase
            end
            if (ctl.commit)
            begin
                if (stamp_we)
                begin
                    stamp_reg <= now_reg;
                end
                if (running_we)
                begin
                    running_reg <= next_task_reg;
                end
                if (task_we)
                begin
                    task_vld_reg[task_addr_reg] <= 1'b1;
                end
                if (irq_we)
                begin
                    irq_vld_reg[irq_addr_reg] <= 1'b1;
                end
            end
        end
    end

    // transaction capture and result register
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg       <= cmd_t'(cmd);
            task_addr_reg <= task_raddr;
            task_ok_reg   <= task_ok;
            irq_addr_reg  <= irq_raddr;
            irq_ok_reg    <= irq_ok;
            // stamp is stable while idle, so the difference is taken here
            elapsed_reg   <= TIME_BITS'(now_time) - stamp_reg;
            now_reg       <= TIME_BITS'(now_time);
            next_task_reg <= next_task;
            set_value_reg <= TIME_BITS'(set_value);
        end
        if (ctl.commit)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

    // memories: read on capture, write on commit; never in the same cycle
    always_ff @(posedge clk)
    begin
        if (ctl.commit && task_we)
        begin
            task_mem[task_addr_reg] <= task_wdata;
        end
        if (ctl.capture)
        begin
            task_rd_reg <= task_vld_reg[task_raddr] ? task_mem[task_raddr] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && irq_we)
        begin
            irq_mem[irq_addr_reg] <= irq_wdata;
        end
        if (ctl.capture)
        begin
            irq_rd_reg <= irq_vld_reg[irq_raddr] ? irq_mem[irq_raddr] : '0;
        end
    end

    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

// File: rtl/core/task_and_irq_exec_time_profiler.sv
// Channel   Handshake           Payload
// in        in_valid/in_stall   cmd, now_time, task_id, next_task, int_num, set_value
// out       out_valid/out_stall read_value, status
// cfg       cfg_we              cfg_index, cfg_data (0 min_int_number, 1 max_int_number)
//
// Each transaction is split: the accept edge reads both counter memories,
// and the commit in ST_EXEC writes the counter back and loads the result register.
// Each counter memory has one read/write port; in_stall stays high until the commit.
// A full result register with out_stall high holds the second step.
// Reset clears all counters at once through per-entry valid bits.
// Top level of the profiler. Depends on tiet_pkg, tiet_ctrl and tiet_dp.
module task_and_irq_exec_time_profiler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tiet_pkg::CMD_W-1:0]      cmd,
    input  logic [tiet_pkg::WORD_W-1:0]     now_time,
    input  logic [tiet_pkg::TASK_W-1:0]     task_id,
    input  logic [tiet_pkg::TASK_W-1:0]     next_task,
    input  logic [tiet_pkg::INT_W-1:0]      int_num,
    input  logic [tiet_pkg::WORD_W-1:0]     set_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tiet_pkg::WORD_W-1:0]     read_value,
    output logic                            status,
    input  logic                            cfg_we,
    input  logic [tiet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tiet_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tiet_pkg::*;

    dp_ctl_t ctl;

    tiet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    tiet_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .now_time   (now_time),
        .task_id    (task_id),
        .next_task  (next_task),
        .int_num    (int_num),
        .set_value  (set_value),
        .read_value (read_value),
        .status     (status)
    );

endmodule
